>>> rtl/safc_pkg.sv
// Package for the set-associative FIFO cache: geometry constants, commands and shared types.
// No dependencies.
package safc_pkg;
	localparam int BLOCK_BYTES = 32;
	localparam int SETS = 16;
	localparam int WAYS = 4;
	localparam int ADDR_BITS = 16;
	localparam int OFF_BITS = $clog2(BLOCK_BYTES);
	localparam int IDX_BITS = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int TAG_BITS = ADDR_BITS - OFF_BITS - $clog2(SETS);
	localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LINES = SETS * WAYS;
	localparam int LINE_BITS = $clog2(LINES);
	localparam int BYTE_ADDR_BITS = LINE_BITS + OFF_BITS;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;
	localparam logic CMD_READ = 1'b0;
	localparam logic CMD_WRITE = 1'b1;
	localparam logic [6:0] RATE_MAX = 7'd100;

	typedef struct packed {
		logic [0:0] command;
		logic [15:0] address;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] data;
		logic hit;
		logic [6:0] miss_rate;
	} rsp_t;

	// Request from the controller to the rate divider.
	typedef struct packed {
		logic start;
		logic [31:0] misses;
		logic [31:0] accesses;
	} div_req_t;
endpackage

>>> rtl/safc_if.sv
// Valid/ready channel interfaces for the request item and the response item.
// Depends on safc_pkg for the payload types.
interface safc_req_if;
	logic valid;
	logic ready;
	safc_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface safc_rsp_if;
	logic valid;
	logic ready;
	safc_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/safc_rate_div.sv
// Iterative miss-rate divider: (misses*100)/accesses, saturated to 100, one quotient bit a cycle.
// Depends on safc_pkg.
module safc_rate_div (
	input logic clk,
	input logic arst_n,
	input safc_pkg::div_req_t req,
	output logic done,
	output logic [6:0] rate
);
	logic [39:0] num_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [39:0] quo_q;
	logic [32:0] trial;
	logic [33:0] sub;

	assign trial = {rem_q[31:0], num_q[39]};
	assign sub = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd40;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {8'b0, req.misses} * 40'd100;
			den_q <= req.accesses;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[38:0], 1'b0};
			if (!sub[33]) begin
				rem_q <= sub[32:0];
				quo_q <= {quo_q[38:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[38:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (den_q == 32'd0) rate = 7'd0;
		else if (quo_q > 40'd100) rate = safc_pkg::RATE_MAX;
		else rate = quo_q[6:0];
	end
endmodule

>>> rtl/set_assoc_fifo_cache_top.sv
// Top level of the set-associative FIFO write-through cache with backing memory.
// Depends on safc_pkg, safc_if and safc_rate_div.
//
//  channel | dir | payload
//  req     | in  | command, address, value
//  rsp     | out | data, hit, miss_rate
//
// One item at a time. After the accepting edge, every item goes through the lookup
// and waits on the bit-serial miss-rate divider, which forms a 40-bit quotient
// between its start and done. A read hit reads its line before the divider, and a
// read miss first copies the 32-byte block from backing memory through the write
// port of the line store. Reset clears valid bits (flip-flops) and the counters;
// the backing memory is cleared by a pass over all 65536 bytes after reset, during
// which no item is accepted. A finished result waits in the output register
// while the next item may already be accepted; that item then stalls before
// its own result until the receiver takes the waiting one.
module set_assoc_fifo_cache_top (
	input logic clk,
	input logic arst_n,
	safc_req_if.sink req,
	safc_rsp_if.source rsp
);
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_LOOK = 4'd2;
	localparam logic [3:0] ST_FILL = 4'd3;
	localparam logic [3:0] ST_READ = 4'd4;
	localparam logic [3:0] ST_RDAT = 4'd5;
	localparam logic [3:0] ST_DIV = 4'd6;
	localparam logic [3:0] ST_WAITDIV = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;

	// One way's tag and fill stamp, packed as {tag, stamp}.
	localparam int META_BITS = safc_pkg::TAG_BITS + 32;

	logic [3:0] state_q;
	logic [safc_pkg::ADDR_BITS:0] clr_q;

	// Valid bits are flops so that reset clears them; tags and stamps of a whole
	// set live in one row of a small memory that is read when the item is accepted.
	logic [safc_pkg::LINES-1:0] valid_q;
	logic [safc_pkg::WAYS*META_BITS-1:0] meta_mem [safc_pkg::SETS];
	logic [safc_pkg::WAYS*META_BITS-1:0] meta_rd, meta_wd;
	logic meta_we;
	logic [safc_pkg::IDX_BITS-1:0] meta_ra;

	// Memories.
	logic [7:0] line_mem [2**safc_pkg::BYTE_ADDR_BITS];
	logic [7:0] back_mem [safc_pkg::MEM_DEPTH];
	logic [7:0] line_rd, back_rd;
	logic line_we, back_we;
	logic [safc_pkg::BYTE_ADDR_BITS-1:0] line_wa, line_ra;
	logic [7:0] line_wd, back_wd;
	logic [safc_pkg::ADDR_BITS-1:0] back_wa, back_ra;

	safc_pkg::req_t cur_q;
	logic [31:0] fill_q, acc_q, miss_q;
	logic hit_q;
	logic [safc_pkg::WAY_BITS-1:0] way_q;
	logic [safc_pkg::OFF_BITS:0] cnt_q;
	logic [7:0] data_q;
	safc_pkg::rsp_t out_q;
	logic out_v_q;
	safc_pkg::div_req_t dreq;
	logic ddone;
	logic [6:0] drate;

	logic [safc_pkg::ADDR_BITS-1:0] addr;
	logic [safc_pkg::OFF_BITS-1:0] off;
	logic [safc_pkg::IDX_BITS-1:0] set;
	logic [safc_pkg::TAG_BITS-1:0] tag;
	logic [safc_pkg::LINE_BITS-1:0] base_line;
	logic mhit;
	logic [safc_pkg::WAY_BITS-1:0] mway, vway;
	logic found_inv;

	assign addr = cur_q.address[safc_pkg::ADDR_BITS-1:0];
	assign off = addr[safc_pkg::OFF_BITS-1:0];
	assign set = addr[safc_pkg::OFF_BITS +: safc_pkg::IDX_BITS];
	assign tag = addr[safc_pkg::ADDR_BITS-1 -: safc_pkg::TAG_BITS];
	assign base_line = safc_pkg::LINE_BITS'(set * safc_pkg::WAYS);

	// Way match and FIFO victim over the four ways of the set.
	always_comb begin
		logic [31:0] best;
		logic [31:0] stamp_w;
		logic [safc_pkg::TAG_BITS-1:0] tag_w;
		logic [safc_pkg::LINE_BITS-1:0] ln;
		mhit = 1'b0;
		mway = '0;
		vway = '0;
		found_inv = 1'b0;
		best = '0;
		stamp_w = '0;
		tag_w = '0;
		ln = '0;
		for (int w = 0; w < safc_pkg::WAYS; w++) begin
			ln = base_line + safc_pkg::LINE_BITS'(w);
			tag_w = meta_rd[w*META_BITS + 32 +: safc_pkg::TAG_BITS];
			if (valid_q[ln] && tag_w == tag) begin
				mhit = 1'b1;
				mway = safc_pkg::WAY_BITS'(w);
			end
		end
		for (int w = safc_pkg::WAYS - 1; w >= 0; w--) begin
			ln = base_line + safc_pkg::LINE_BITS'(w);
			if (!valid_q[ln]) begin
				found_inv = 1'b1;
				vway = safc_pkg::WAY_BITS'(w);
			end
		end
		if (!found_inv) begin
			best = meta_rd[0 +: 32];
			vway = '0;
			for (int w = 1; w < safc_pkg::WAYS; w++) begin
				stamp_w = meta_rd[w*META_BITS +: 32];
				if (stamp_w < best) begin
					best = stamp_w;
					vway = safc_pkg::WAY_BITS'(w);
				end
			end
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.payload = out_q;

	// Tag and stamp rows: read the set of an arriving item at its accepting edge,
	// write the refilled way back at the end of the block copy.
	always_comb begin
		meta_ra = set;
		if (req.valid && req.ready)
			meta_ra = req.payload.address[safc_pkg::OFF_BITS +: safc_pkg::IDX_BITS];
		meta_we = (state_q == ST_FILL) &&
			(cnt_q == (safc_pkg::OFF_BITS+1)'(safc_pkg::BLOCK_BYTES));
		meta_wd = meta_rd;
		meta_wd[way_q*META_BITS +: META_BITS] = {tag, fill_q + 32'd1};
	end

	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[set] <= meta_wd;
		meta_rd <= meta_mem[meta_ra];
	end

	// Memory port control.
	always_comb begin
		line_we = 1'b0;
		line_wa = {base_line + safc_pkg::LINE_BITS'(way_q), off};
		line_wd = cur_q.value;
		line_ra = {base_line + safc_pkg::LINE_BITS'(way_q), off};
		back_we = 1'b0;
		back_wa = addr;
		back_wd = cur_q.value;
		back_ra = {addr[safc_pkg::ADDR_BITS-1:safc_pkg::OFF_BITS],
			cnt_q[safc_pkg::OFF_BITS-1:0]};
		case (state_q)
			ST_CLEAR: begin
				back_we = 1'b1;
				back_wa = clr_q[safc_pkg::ADDR_BITS-1:0];
				back_wd = 8'd0;
			end
			ST_LOOK: begin
				if (cur_q.command == safc_pkg::CMD_WRITE) begin
					back_we = 1'b1;
					line_we = mhit;
					line_wa = {base_line + safc_pkg::LINE_BITS'(mway), off};
				end
			end
			ST_FILL: begin
				// Data read last cycle lands at byte cnt-1.
				line_we = cnt_q != '0;
				line_wa = {base_line + safc_pkg::LINE_BITS'(way_q),
					safc_pkg::OFF_BITS'(cnt_q - 1'b1)};
				line_wd = back_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_wa] <= line_wd;
		line_rd <= line_mem[line_ra];
		if (back_we) back_mem[back_wa] <= back_wd;
		back_rd <= back_mem[back_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			valid_q <= '0;
			fill_q <= '0;
			acc_q <= '0;
			miss_q <= '0;
			out_v_q <= 1'b0;
			dreq <= '0;
			hit_q <= 1'b0;
			way_q <= '0;
			cnt_q <= '0;
			data_q <= '0;
		end else begin
			dreq.start <= (state_q == ST_DIV);
			if (state_q == ST_OUT && (!out_v_q || rsp.ready))
				out_v_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				out_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (safc_pkg::ADDR_BITS+1)'(safc_pkg::MEM_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (req.valid && req.ready) state_q <= ST_LOOK;
				ST_LOOK: begin
					acc_q <= acc_q + 32'd1;
					hit_q <= mhit;
					if (!mhit) miss_q <= miss_q + 32'd1;
					if (cur_q.command == safc_pkg::CMD_WRITE) begin
						data_q <= 8'd0;
						state_q <= ST_DIV;
					end else if (mhit) begin
						way_q <= mway;
						state_q <= ST_READ;
					end else begin
						way_q <= vway;
						cnt_q <= '0;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (safc_pkg::OFF_BITS+1)'(safc_pkg::BLOCK_BYTES)) begin
						valid_q[base_line + safc_pkg::LINE_BITS'(way_q)] <= 1'b1;
						fill_q <= fill_q + 32'd1;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_RDAT;
				ST_RDAT: begin
					data_q <= line_rd;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dreq.misses <= miss_q;
					dreq.accesses <= acc_q;
					state_q <= ST_WAITDIV;
				end
				ST_WAITDIV: if (ddone) state_q <= ST_OUT;
				ST_OUT: if (!out_v_q || rsp.ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) cur_q <= req.payload;
		if (state_q == ST_OUT && (!out_v_q || rsp.ready)) begin
			out_q.data <= data_q;
			out_q.hit <= hit_q;
			out_q.miss_rate <= drate;
		end
	end

	safc_rate_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .rate(drate)
	);

	// A miss counter can never run ahead of the access counter by more than wrap.
	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.payload.miss_rate <= safc_pkg::RATE_MAX)
		else $error("miss rate above 100");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q == ST_LOOK)
		else $error("accept did not start a lookup");
	a_fill_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> cnt_q <= (safc_pkg::OFF_BITS+1)'(safc_pkg::BLOCK_BYTES))
		else $error("fill overran the block");
endmodule
